/* design/segment_pair_intersection_defines.svh */
// ----------------------------------------------------------------------------
// Segment pair intersection: assertion macros
// Concurrent assertion wrappers shared by the top module and the divider.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_PAIR_INTERSECTION_DEFINES_SVH
`define SEGMENT_PAIR_INTERSECTION_DEFINES_SVH

`ifndef ASSERT_OFF
`define SPI_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SPI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPI_ASSERT(lbl, clk, rstn, prop, msg)
`define SPI_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* design/spi_pkg.sv */
// ----------------------------------------------------------------------------
// Segment pair intersection package
// Default parameters and the sign/flag group passed down the pipeline.
// ----------------------------------------------------------------------------
package spi_pkg;

  localparam int unsigned SPI_COORD_BITS = 16;
  localparam int unsigned SPI_FRAC_BITS  = 16;
  localparam int unsigned SPI_OUT_BITS   = 32;

  typedef struct packed {
    logic hit;
    logic xneg;
    logic yneg;
    logic dneg;
  } spi_flags_t;

endpackage

/* design/spi_if.sv */
// ----------------------------------------------------------------------------
// Segment pair intersection channels
// Valid/ready interfaces for the segment pair input and the crossing result.
// ----------------------------------------------------------------------------
interface spi_in_if #(
  parameter int unsigned CW = spi_pkg::SPI_COORD_BITS
) ();
  logic valid;
  logic ready;
  logic signed [CW-1:0] a_x1;
  logic signed [CW-1:0] a_y1;
  logic signed [CW-1:0] a_x2;
  logic signed [CW-1:0] a_y2;
  logic signed [CW-1:0] b_x1;
  logic signed [CW-1:0] b_y1;
  logic signed [CW-1:0] b_x2;
  logic signed [CW-1:0] b_y2;

  modport source (
    output valid, a_x1, a_y1, a_x2, a_y2, b_x1, b_y1, b_x2, b_y2,
    input  ready
  );
  modport sink (
    input  valid, a_x1, a_y1, a_x2, a_y2, b_x1, b_y1, b_x2, b_y2,
    output ready
  );
endinterface

interface spi_out_if ();
  logic valid;
  logic ready;
  logic hit;
  logic signed [31:0] x_point;
  logic signed [31:0] y_point;

  modport source (output valid, hit, x_point, y_point, input ready);
  modport sink (input valid, hit, x_point, y_point, output ready);
endinterface

/* design/segment_pair_intersection.sv */
// Throughput: one segment pair per cycle while no result is held; the divider retires one quotient bit per stage.
// The whole pipeline holds while a result waits and the output is not ready.
// Reset clears all valid bits asynchronously; payload registers are not reset.
// ----------------------------------------------------------------------------
// Segment pair intersection
// Proper crossing test for two integer segments with the crossing point in
// signed fixed point, truncated toward zero.
// ----------------------------------------------------------------------------
`include "segment_pair_intersection_defines.svh"

module segment_pair_intersection #(
  parameter int unsigned COORD_BITS = spi_pkg::SPI_COORD_BITS,
  parameter int unsigned FRAC_BITS  = spi_pkg::SPI_FRAC_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  spi_in_if.sink    seg_i,
  spi_out_if.source res_o
);
  import spi_pkg::*;

  localparam int unsigned CW = COORD_BITS;

  logic en;
  logic c_vld, c_hit, p_vld;
  logic signed [2*CW+2:0] c_num, c_den;
  logic signed [CW-1:0]   c_ax1, c_ay1;
  logic signed [CW:0]     c_v1x, c_v1y;
  spi_flags_t             p_flags;
  logic [3*CW+4:0]        p_mx, p_my;
  logic [2*CW+2:0]        p_dm;

  // Every stage advances together unless a finished result is held.
  assign en          = !res_o.valid || res_o.ready;
  assign seg_i.ready = en;

  spi_cross #(.CW(CW)) u_cross (
    .clk_i, .rst_ni, .en_i(en), .valid_i(seg_i.valid),
    .ax1_i(seg_i.a_x1), .ay1_i(seg_i.a_y1), .ax2_i(seg_i.a_x2), .ay2_i(seg_i.a_y2),
    .bx1_i(seg_i.b_x1), .by1_i(seg_i.b_y1), .bx2_i(seg_i.b_x2), .by2_i(seg_i.b_y2),
    .valid_o(c_vld), .hit_o(c_hit), .num_o(c_num), .den_o(c_den),
    .ax1_o(c_ax1), .ay1_o(c_ay1), .v1x_o(c_v1x), .v1y_o(c_v1y)
  );

  spi_point #(.CW(CW)) u_point (
    .clk_i, .rst_ni, .en_i(en), .valid_i(c_vld), .hit_i(c_hit),
    .num_i(c_num), .den_i(c_den), .ax1_i(c_ax1), .ay1_i(c_ay1),
    .v1x_i(c_v1x), .v1y_i(c_v1y),
    .valid_o(p_vld), .flags_o(p_flags), .mx_o(p_mx), .my_o(p_my), .dmag_o(p_dm)
  );

  spi_div #(.CW(CW), .FW(FRAC_BITS)) u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(p_vld), .flags_i(p_flags),
    .mx_i(p_mx), .my_i(p_my), .dmag_i(p_dm),
    .valid_o(res_o.valid), .hit_o(res_o.hit), .x_o(res_o.x_point), .y_o(res_o.y_point)
  );

  `SPI_ASSERT(a_miss_zero_point, clk_i, rst_ni, (res_o.valid && !res_o.hit) |-> ((res_o.x_point == '0) && (res_o.y_point == '0)), "miss with nonzero point")
  `SPI_ASSERT(a_stall_only_held, clk_i, rst_ni, !seg_i.ready |-> (res_o.valid && !res_o.ready), "input stalled without a held result")
  `SPI_ASSERT_ALWAYS(a_reset_no_result, clk_i, !rst_ni |=> !res_o.valid, "result valid during reset")

endmodule

/* design/spi_cross.sv */
// ----------------------------------------------------------------------------
// Segment pair intersection: orientation stages
// Three stages: coordinate differences, cross product terms, and the
// orientation compares that decide a hit.
// ----------------------------------------------------------------------------
module spi_cross #(
  parameter int unsigned CW = spi_pkg::SPI_COORD_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [CW-1:0] ax1_i,
  input  logic signed [CW-1:0] ay1_i,
  input  logic signed [CW-1:0] ax2_i,
  input  logic signed [CW-1:0] ay2_i,
  input  logic signed [CW-1:0] bx1_i,
  input  logic signed [CW-1:0] by1_i,
  input  logic signed [CW-1:0] bx2_i,
  input  logic signed [CW-1:0] by2_i,
  output logic                 valid_o,
  output logic                 hit_o,
  output logic signed [2*CW+2:0] num_o,
  output logic signed [2*CW+2:0] den_o,
  output logic signed [CW-1:0] ax1_o,
  output logic signed [CW-1:0] ay1_o,
  output logic signed [CW:0]   v1x_o,
  output logic signed [CW:0]   v1y_o
);
  localparam int unsigned DW = CW + 1;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned XW = PW + 1;

  // Stage 1: differences.
  logic s1_vld_q;
  logic signed [DW-1:0] v1x_q, v1y_q, v2x_q, v2y_q, wx_q, wy_q, ex_q, ey_q, fx_q, fy_q;
  logic signed [CW-1:0] ax1_s1_q, ay1_s1_q;

  // Stage 2: products.
  logic s2_vld_q;
  logic signed [PW-1:0] p1a_q, p1b_q, p2a_q, p2b_q, pna_q, pnb_q, p4a_q, p4b_q, pda_q, pdb_q;
  logic signed [CW-1:0] ax1_s2_q, ay1_s2_q;
  logic signed [DW-1:0] v1x_s2_q, v1y_s2_q;

  // Stage 3: cross products and orientation.
  logic s3_vld_q, hit_q;
  logic signed [XW-1:0] num_q, den_q;
  logic signed [CW-1:0] ax1_s3_q, ay1_s3_q;
  logic signed [DW-1:0] v1x_s3_q, v1y_s3_q;

  logic signed [XW-1:0] c1, c2, c4, cn, cd;
  logic hit_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else if (en_i) begin
      s1_vld_q <= valid_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v1x_q    <= DW'(ax2_i) - DW'(ax1_i);
      v1y_q    <= DW'(ay2_i) - DW'(ay1_i);
      v2x_q    <= DW'(bx2_i) - DW'(bx1_i);
      v2y_q    <= DW'(by2_i) - DW'(by1_i);
      wx_q     <= DW'(bx1_i) - DW'(ax1_i);
      wy_q     <= DW'(by1_i) - DW'(ay1_i);
      ex_q     <= DW'(bx2_i) - DW'(ax1_i);
      ey_q     <= DW'(by2_i) - DW'(ay1_i);
      fx_q     <= DW'(ax2_i) - DW'(bx1_i);
      fy_q     <= DW'(ay2_i) - DW'(by1_i);
      ax1_s1_q <= ax1_i;
      ay1_s1_q <= ay1_i;

      p1a_q    <= PW'(v1x_q) * PW'(wy_q);
      p1b_q    <= PW'(v1y_q) * PW'(wx_q);
      p2a_q    <= PW'(v1x_q) * PW'(ey_q);
      p2b_q    <= PW'(v1y_q) * PW'(ex_q);
      pna_q    <= PW'(wx_q) * PW'(v2y_q);
      pnb_q    <= PW'(wy_q) * PW'(v2x_q);
      p4a_q    <= PW'(v2x_q) * PW'(fy_q);
      p4b_q    <= PW'(v2y_q) * PW'(fx_q);
      pda_q    <= PW'(v1x_q) * PW'(v2y_q);
      pdb_q    <= PW'(v1y_q) * PW'(v2x_q);
      ax1_s2_q <= ax1_s1_q;
      ay1_s2_q <= ay1_s1_q;
      v1x_s2_q <= v1x_q;
      v1y_s2_q <= v1y_q;

      hit_q    <= hit_d;
      num_q    <= cn;
      den_q    <= cd;
      ax1_s3_q <= ax1_s2_q;
      ay1_s3_q <= ay1_s2_q;
      v1x_s3_q <= v1x_s2_q;
      v1y_s3_q <= v1y_s2_q;
    end
  end

  always_comb begin
    c1 = XW'(p1a_q) - XW'(p1b_q);
    c2 = XW'(p2a_q) - XW'(p2b_q);
    cn = XW'(pna_q) - XW'(pnb_q);
    c4 = XW'(p4a_q) - XW'(p4b_q);
    cd = XW'(pda_q) - XW'(pdb_q);
    // The orientation of A's first end against B is the numerator itself.
    hit_d = ((c1 > 0) != (c2 > 0)) && ((cn > 0) != (c4 > 0)) && (cd != '0);
  end

  assign valid_o = s3_vld_q;
  assign hit_o   = hit_q;
  assign num_o   = num_q;
  assign den_o   = den_q;
  assign ax1_o   = ax1_s3_q;
  assign ay1_o   = ay1_s3_q;
  assign v1x_o   = v1x_s3_q;
  assign v1y_o   = v1y_s3_q;

endmodule

/* design/spi_point.sv */
// ----------------------------------------------------------------------------
// Segment pair intersection: dividend stages
// Forms base*den + delta*num for both axes from split partial products,
// then takes magnitudes and signs for the divider.
// ----------------------------------------------------------------------------
module spi_point #(
  parameter int unsigned CW = spi_pkg::SPI_COORD_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic                     hit_i,
  input  logic signed [2*CW+2:0]   num_i,
  input  logic signed [2*CW+2:0]   den_i,
  input  logic signed [CW-1:0]     ax1_i,
  input  logic signed [CW-1:0]     ay1_i,
  input  logic signed [CW:0]       v1x_i,
  input  logic signed [CW:0]       v1y_i,
  output logic                     valid_o,
  output spi_pkg::spi_flags_t      flags_o,
  output logic [3*CW+4:0]          mx_o,
  output logic [3*CW+4:0]          my_o,
  output logic [2*CW+2:0]          dmag_o
);
  import spi_pkg::*;

  localparam int unsigned XW = 2 * CW + 3;
  localparam int unsigned MW = 3 * CW + 5;
  localparam int unsigned L  = CW + 2;
  localparam int unsigned HW = XW - L;
  localparam int unsigned BW = CW + L + 2;
  localparam int unsigned TW = CW + HW + 1;

  logic signed [L:0]    den_lo, num_lo;
  logic signed [HW-1:0] den_hi, num_hi;

  // Stage 4: partial products.
  logic s4_vld_q, s4_hit_q;
  logic signed [BW-1:0] xbl_q, xnl_q, ybl_q, ynl_q;
  logic signed [TW-1:0] xbh_q, xnh_q, ybh_q, ynh_q;
  logic signed [XW-1:0] s4_den_q;

  // Stage 5: dividends.
  logic s5_vld_q, s5_hit_q;
  logic signed [MW-1:0] mx_q, my_q;
  logic signed [XW-1:0] s5_den_q;

  // Stage 6: magnitudes.
  logic s6_vld_q;
  spi_flags_t flags_q;
  logic [MW-1:0] mxm_q, mym_q;
  logic [XW-1:0] dm_q;

  assign den_lo = $signed({1'b0, den_i[L-1:0]});
  assign num_lo = $signed({1'b0, num_i[L-1:0]});
  assign den_hi = den_i[XW-1:L];
  assign num_hi = num_i[XW-1:L];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
      s6_vld_q <= 1'b0;
    end else if (en_i) begin
      s4_vld_q <= valid_i;
      s5_vld_q <= s4_vld_q;
      s6_vld_q <= s5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xbl_q    <= BW'(ax1_i) * BW'(den_lo);
      xbh_q    <= TW'(ax1_i) * TW'(den_hi);
      xnl_q    <= BW'(v1x_i) * BW'(num_lo);
      xnh_q    <= TW'(v1x_i) * TW'(num_hi);
      ybl_q    <= BW'(ay1_i) * BW'(den_lo);
      ybh_q    <= TW'(ay1_i) * TW'(den_hi);
      ynl_q    <= BW'(v1y_i) * BW'(num_lo);
      ynh_q    <= TW'(v1y_i) * TW'(num_hi);
      s4_den_q <= den_i;
      s4_hit_q <= hit_i;

      mx_q     <= (MW'(xbh_q) <<< L) + MW'(xbl_q) + (MW'(xnh_q) <<< L) + MW'(xnl_q);
      my_q     <= (MW'(ybh_q) <<< L) + MW'(ybl_q) + (MW'(ynh_q) <<< L) + MW'(ynl_q);
      s5_den_q <= s4_den_q;
      s5_hit_q <= s4_hit_q;

      flags_q.hit  <= s5_hit_q;
      flags_q.xneg <= mx_q[MW-1];
      flags_q.yneg <= my_q[MW-1];
      flags_q.dneg <= s5_den_q[XW-1];
      mxm_q <= mx_q[MW-1] ? MW'(-mx_q) : MW'(mx_q);
      mym_q <= my_q[MW-1] ? MW'(-my_q) : MW'(my_q);
      dm_q  <= s5_den_q[XW-1] ? XW'(-s5_den_q) : XW'(s5_den_q);
    end
  end

  assign valid_o = s6_vld_q;
  assign flags_o = flags_q;
  assign mx_o    = mxm_q;
  assign my_o    = mym_q;
  assign dmag_o  = dm_q;

endmodule

/* design/spi_div.sv */
// ----------------------------------------------------------------------------
// Segment pair intersection: pipelined divider
// Restoring division, one quotient bit per stage for both axes, followed by
// the sign, saturation and output register.
// ----------------------------------------------------------------------------
`include "segment_pair_intersection_defines.svh"

module spi_div #(
  parameter int unsigned CW = spi_pkg::SPI_COORD_BITS,
  parameter int unsigned FW = spi_pkg::SPI_FRAC_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  spi_pkg::spi_flags_t flags_i,
  input  logic [3*CW+4:0]     mx_i,
  input  logic [3*CW+4:0]     my_i,
  input  logic [2*CW+2:0]     dmag_i,
  output logic                valid_o,
  output logic                hit_o,
  output logic signed [31:0]  x_o,
  output logic signed [31:0]  y_o
);
  import spi_pkg::*;

  localparam int unsigned XW = 2 * CW + 3;
  localparam int unsigned RW = XW + 1;
  localparam int unsigned MW = 3 * CW + 5;
  localparam int unsigned NW = MW + FW;
  localparam int unsigned Q  = CW + FW + 1;
  localparam int unsigned QE = Q + SPI_OUT_BITS + 1;
  localparam logic [QE-1:0] LIM_POS = QE'(64'h7FFF_FFFF);
  localparam logic [QE-1:0] LIM_NEG = QE'(64'h8000_0000);

  logic [NW-1:0] nx, ny;

  logic          vld_q [Q+1];
  spi_flags_t    flg_q [Q+1];
  logic [XW-1:0] d_q   [Q+1];
  logic [RW-1:0] rx_q  [Q+1];
  logic [RW-1:0] ry_q  [Q+1];
  logic [Q-1:0]  zx_q  [Q+1];
  logic [Q-1:0]  zy_q  [Q+1];

  logic               out_vld_q, out_hit_q;
  logic signed [31:0] out_x_q, out_y_q;

  function automatic logic [31:0] spi_sat(input logic [Q-1:0] q, input logic neg);
    logic [QE-1:0] qe;
    logic [31:0]   v;
    qe = QE'(q);
    if (neg && (qe != '0)) begin
      v = (qe > LIM_NEG) ? 32'h8000_0000 : 32'(LIM_NEG - qe + LIM_NEG);
    end else begin
      v = (qe > LIM_POS) ? 32'h7FFF_FFFF : qe[31:0];
    end
    return v;
  endfunction

  assign nx = NW'(mx_i) << FW;
  assign ny = NW'(my_i) << FW;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  // The upper dividend bits are already below the divisor, since the
  // quotient always fits in Q bits.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      flg_q[0] <= flags_i;
      d_q[0]   <= dmag_i;
      rx_q[0]  <= nx[Q+RW-1:Q];
      ry_q[0]  <= ny[Q+RW-1:Q];
      zx_q[0]  <= nx[Q-1:0];
      zy_q[0]  <= ny[Q-1:0];
    end
  end

  for (genvar s = 0; s < Q; s++) begin : g_step
    logic [RW-1:0] tx, ty;
    logic          bx, by;

    always_comb begin
      tx = {rx_q[s][XW-1:0], zx_q[s][Q-1]};
      ty = {ry_q[s][XW-1:0], zy_q[s][Q-1]};
      bx = (tx >= {1'b0, d_q[s]});
      by = (ty >= {1'b0, d_q[s]});
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        flg_q[s+1] <= flg_q[s];
        d_q[s+1]   <= d_q[s];
        rx_q[s+1]  <= bx ? (tx - {1'b0, d_q[s]}) : tx;
        ry_q[s+1]  <= by ? (ty - {1'b0, d_q[s]}) : ty;
        zx_q[s+1]  <= {zx_q[s][Q-2:0], bx};
        zy_q[s+1]  <= {zy_q[s][Q-2:0], by};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      out_vld_q <= vld_q[Q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_hit_q <= flg_q[Q].hit;
      out_x_q   <= flg_q[Q].hit ? spi_sat(zx_q[Q], flg_q[Q].xneg != flg_q[Q].dneg) : '0;
      out_y_q   <= flg_q[Q].hit ? spi_sat(zy_q[Q], flg_q[Q].yneg != flg_q[Q].dneg) : '0;
    end
  end

  assign valid_o = out_vld_q;
  assign hit_o   = out_hit_q;
  assign x_o     = out_x_q;
  assign y_o     = out_y_q;

  `SPI_ASSERT(a_rem_x_below_div, clk_i, rst_ni, (vld_q[Q] && flg_q[Q].hit) |-> (rx_q[Q] < {1'b0, d_q[Q]}), "x remainder not below divisor")
  `SPI_ASSERT(a_rem_y_below_div, clk_i, rst_ni, (vld_q[Q] && flg_q[Q].hit) |-> (ry_q[Q] < {1'b0, d_q[Q]}), "y remainder not below divisor")
  `SPI_ASSERT(a_hit_nonzero_div, clk_i, rst_ni, (vld_q[0] && flg_q[0].hit) |-> (d_q[0] != '0), "hit with zero divisor")

endmodule

/* tb/sv/tb_segment_pair_intersection.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment pair intersection testbench
// Streams segment pairs into the block, a directed table first and then random
// pairs, and compares every result with the table's expected value or a crossing predictor kept here.
// ----------------------------------------------------------------------------
module tb_segment_pair_intersection;

  localparam int unsigned CW        = spi_pkg::SPI_COORD_BITS;
  localparam int unsigned FRAC      = spi_pkg::SPI_FRAC_BITS;
  localparam int          LATENCY   = CW + FRAC + 9;
  localparam int          N_RANDOM  = 1880;
  localparam int          MAX_CYCLES = 400000;

  typedef struct {
    logic signed [CW-1:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
  } seg_pair_t;

  typedef struct {
    logic               hit;
    logic signed [31:0] x_point;
    logic signed [31:0] y_point;
  } crossing_t;

  typedef struct {
    seg_pair_t pair;
    logic      typed;
    crossing_t want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  spi_in_if  #(.CW(CW)) seg_if ();
  spi_out_if            res_if ();

  segment_pair_intersection #(.COORD_BITS(CW), .FRAC_BITS(FRAC)) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .seg_i  (seg_if.sink),
    .res_o  (res_if.source)
  );

  crossing_t pending_crossings[$];
  int        error_count = 0;
  bit        stimulus_done = 1'b0;
  bit        hold_off_done = 1'b0;
  int        accepted_count = 0;
  longint    cycle_count = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic longint cross_prod(longint ux, longint uy, longint vx, longint vy);
    return ux * vy - uy * vx;
  endfunction

  // Exact base + delta*num/den scaled to fixed point, truncated toward zero.
  function automatic logic signed [31:0] fixed_coord(longint base, longint delta,
                                                      longint num, longint den);
    logic signed [127:0] m;
    logic signed [127:0] d;
    logic signed [127:0] q;
    m = 128'(base);
    m = m * 128'(den);
    d = 128'(delta);
    m = m + d * 128'(num);
    m = m <<< FRAC;
    d = 128'(den);
    q = m / d;
    if (q > 128'sd2147483647) return 32'h7fff_ffff;
    if (q < -128'sd2147483648) return 32'h8000_0000;
    return q[31:0];
  endfunction

  function automatic crossing_t predict_crossing(seg_pair_t p);
    crossing_t r;
    longint ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
    longint v1x, v1y, v2x, v2y, den, num;
    bit o1, o2, o3, o4;
    ax1 = 64'(p.ax1); ay1 = 64'(p.ay1); ax2 = 64'(p.ax2); ay2 = 64'(p.ay2);
    bx1 = 64'(p.bx1); by1 = 64'(p.by1); bx2 = 64'(p.bx2); by2 = 64'(p.by2);
    v1x = ax2 - ax1; v1y = ay2 - ay1;
    v2x = bx2 - bx1; v2y = by2 - by1;
    o1 = cross_prod(v1x, v1y, bx1 - ax1, by1 - ay1) > 0;
    o2 = cross_prod(v1x, v1y, bx2 - ax1, by2 - ay1) > 0;
    o3 = cross_prod(v2x, v2y, ax1 - bx1, ay1 - by1) > 0;
    o4 = cross_prod(v2x, v2y, ax2 - bx1, ay2 - by1) > 0;
    r.hit = 1'b0;
    r.x_point = '0;
    r.y_point = '0;
    if (o1 == o2 || o3 == o4) return r;
    den = cross_prod(v1x, v1y, v2x, v2y);
    if (den == 0) return r;
    num = cross_prod(bx1 - ax1, by1 - ay1, v2x, v2y);
    r.hit = 1'b1;
    r.x_point = fixed_coord(ax1, v1x, num, den);
    r.y_point = fixed_coord(ay1, v1y, num, den);
    return r;
  endfunction

  function automatic seg_pair_t mk_pair(int ax1, int ay1, int ax2, int ay2,
                                        int bx1, int by1, int bx2, int by2);
    seg_pair_t p;
    p.ax1 = CW'(ax1); p.ay1 = CW'(ay1); p.ax2 = CW'(ax2); p.ay2 = CW'(ay2);
    p.bx1 = CW'(bx1); p.by1 = CW'(by1); p.bx2 = CW'(bx2); p.by2 = CW'(by2);
    return p;
  endfunction

  function automatic crossing_t mk_crossing(logic hit, int xp, int yp);
    crossing_t c;
    c.hit = hit;
    c.x_point = xp;
    c.y_point = yp;
    return c;
  endfunction

  function automatic logic signed [CW-1:0] rand_coord(bit narrow);
    if (narrow) return CW'($urandom_range(8) - 4);
    return CW'($urandom());
  endfunction

  // Drives one pair and returns after the transfer edge; valid stays high.
  task automatic send_pair(seg_pair_t p, bit typed, crossing_t want);
    seg_if.valid <= 1'b1;
    seg_if.a_x1 <= p.ax1; seg_if.a_y1 <= p.ay1;
    seg_if.a_x2 <= p.ax2; seg_if.a_y2 <= p.ay2;
    seg_if.b_x1 <= p.bx1; seg_if.b_y1 <= p.by1;
    seg_if.b_x2 <= p.bx2; seg_if.b_y2 <= p.by2;
    @(negedge clk_i);
    while (!seg_if.ready) @(negedge clk_i);
    if (typed) pending_crossings.push_back(want);
    else pending_crossings.push_back(predict_crossing(p));
    @(posedge clk_i);
    accepted_count++;
  endtask

  task automatic idle_cycles(int n);
    seg_if.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain_results();
    seg_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_crossings.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    stim_row_t table_rows[$];
    seg_pair_t p;
    crossing_t none;
    int burst;
    int sent;
    bit narrow;

    seg_if.valid = 1'b0;
    seg_if.a_x1 = '0; seg_if.a_y1 = '0; seg_if.a_x2 = '0; seg_if.a_y2 = '0;
    seg_if.b_x1 = '0; seg_if.b_y1 = '0; seg_if.b_x2 = '0; seg_if.b_y2 = '0;
    none = mk_crossing(1'b0, 0, 0);

    // Typed rows are no-crossing cases or crossings that can be read directly.
    table_rows.push_back('{mk_pair(0, 0, 0, 0, 0, 0, 0, 0), 1'b1, none});
    table_rows.push_back('{mk_pair(-1, 0, 1, 0, 0, -1, 0, 1), 1'b1,
                           mk_crossing(1'b1, 0, 0)});
    table_rows.push_back('{mk_pair(0, -1, 0, 1, -1, 0, 1, 0), 1'b1,
                           mk_crossing(1'b1, 0, 0)});
    table_rows.push_back('{mk_pair(-32768, -32768, 32767, 32767,
                                   -32768, 32767, 32767, -32768), 1'b0, none});
    table_rows.push_back('{mk_pair(32767, -32768, -32768, 32767,
                                   32767, 32767, -32768, -32768), 1'b0, none});
    table_rows.push_back('{mk_pair(-32768, -32768, -32768, -32768,
                                   -32768, -32768, -32768, -32768), 1'b1, none});
    table_rows.push_back('{mk_pair(32767, 32767, 32767, 32767,
                                   32767, 32767, 32767, 32767), 1'b1, none});
    // Parallel lines.
    table_rows.push_back('{mk_pair(0, 0, 10, 0, 0, 5, 10, 5), 1'b1, none});
    // Collinear overlap is not reported.
    table_rows.push_back('{mk_pair(0, 0, 10, 10, 5, 5, 20, 20), 1'b1, none});
    // Zero-length segment lying on the other one.
    table_rows.push_back('{mk_pair(0, 0, 10, 0, 5, 0, 5, 0), 1'b1, none});
    // Touching at an endpoint and T-junctions, both orientations.
    table_rows.push_back('{mk_pair(0, 0, 10, 0, 10, 0, 10, 10), 1'b0, none});
    table_rows.push_back('{mk_pair(0, 0, 10, 0, 5, 0, 5, 10), 1'b0, none});
    table_rows.push_back('{mk_pair(0, 0, 10, 0, 5, 0, 5, -10), 1'b0, none});
    table_rows.push_back('{mk_pair(5, 0, 5, -10, 0, 0, 10, 0), 1'b0, none});
    // Disjoint segments on crossing lines.
    table_rows.push_back('{mk_pair(0, 0, 1, 1, 10, 0, 9, 1), 1'b1, none});
    // Fractional crossing points, negative and positive.
    table_rows.push_back('{mk_pair(0, 0, 3, 1, 0, 1, 1, -2), 1'b0, none});
    table_rows.push_back('{mk_pair(-3, -7, 5, 2, -6, 4, 7, -5), 1'b0, none});
    table_rows.push_back('{mk_pair(-32768, 0, 32767, 1, 0, -32768, 1, 32767), 1'b0, none});
    table_rows.push_back('{mk_pair(-32768, 32767, 32767, -32767,
                                   -32767, -32768, 32766, 32767), 1'b0, none});

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (table_rows[i]) begin
      send_pair(table_rows[i].pair, table_rows[i].typed, table_rows[i].want);
      if ($urandom_range(3) == 0) idle_cycles($urandom_range(3, 1));
    end
    drain_results();

    sent = 0;
    while (sent < N_RANDOM) begin
      burst = $urandom_range(40, 1);
      for (int k = 0; k < burst && sent < N_RANDOM; k++) begin
        narrow = ($urandom_range(3) == 0);
        p.ax1 = rand_coord(narrow); p.ay1 = rand_coord(narrow);
        p.ax2 = rand_coord(narrow); p.ay2 = rand_coord(narrow);
        p.bx1 = rand_coord(narrow); p.by1 = rand_coord(narrow);
        p.bx2 = rand_coord(narrow); p.by2 = rand_coord(narrow);
        send_pair(p, 1'b0, none);
        sent++;
      end
      if (sent == N_RANDOM / 2) drain_results();
      else if ($urandom_range(2) != 0) idle_cycles($urandom_range(6, 1));
    end
    seg_if.valid <= 1'b0;
    stimulus_done = 1'b1;

    while (pending_crossings.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Receiver: a stall pattern of its own, with one long hold-off early on.
  initial begin
    int phase;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    phase = 0;
    forever begin
      @(posedge clk_i);
      if (!hold_off_done && accepted_count > 100) begin
        res_if.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_off_done = 1'b1;
      end
      phase = (phase + 1) % 64;
      if (phase < 16) res_if.ready <= 1'b1;
      else if (phase < 40) res_if.ready <= ($urandom_range(3) != 0);
      else res_if.ready <= ($urandom_range(1) != 0);
    end
  end

  // Results are sampled mid-cycle; a transfer happens at the next rising edge.
  always @(negedge clk_i) begin
    crossing_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_crossings.size() == 0) begin
        $error("result transfer with no pair outstanding");
        error_count++;
      end else begin
        want = pending_crossings.pop_front();
        if (res_if.hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, res_if.hit);
          error_count++;
        end
        if (res_if.x_point !== want.x_point) begin
          $error("x_point: expected %0d, got %0d", want.x_point, res_if.x_point);
          error_count++;
        end
        if (res_if.y_point !== want.y_point) begin
          $error("y_point: expected %0d, got %0d", want.y_point, res_if.y_point);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == MAX_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule
